>>> sv/pcfc_pkg.sv
// Shared types and constants for the pixel color family classifier.
// No dependencies; imported by pcfc_classify and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pcfc_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned FAM_W = 4;

  // Hue accumulator t = hue * spread / 60, always below 6 * spread.
  localparam int unsigned HUE_T_W = PIX_W + 3;
  // Compare width: 4 * t against boundary_over_15 * spread.
  localparam int unsigned HUE_C_W = HUE_T_W + 2;

  typedef enum logic [FAM_W-1:0] {
    FAM_WHITE     = 4'd0,
    FAM_LIGHTGRAY = 4'd1,
    FAM_GRAY      = 4'd2,
    FAM_DARKGRAY  = 4'd3,
    FAM_BLACK     = 4'd4,
    FAM_RED       = 4'd5,
    FAM_PEACH     = 4'd6,
    FAM_YELLOW    = 4'd7,
    FAM_GREEN     = 4'd8,
    FAM_BLUE      = 4'd9,
    FAM_MAUVE     = 4'd10,
    FAM_PINK      = 4'd11
  } family_t;

  // Achromatic thresholds
  localparam logic [PIX_W-1:0] WHITE_MAX_MIN  = 8'd245;
  localparam logic [PIX_W-1:0] WHITE_MIN_MIN  = 8'd235;
  localparam logic [PIX_W-1:0] BLACK_MAX_MAX  = 8'd22;
  localparam logic [PIX_W-1:0] GRAY_SPREAD    = 8'd14;
  localparam logic [PIX_W-1:0] LIGHTGRAY_MIN  = 8'd205;
  localparam logic [PIX_W-1:0] GRAY_MIN       = 8'd110;

  // Hue boundaries in degrees divided by 15 (15, 45, 75, 165, 255, 315, 345)
  localparam logic [4:0] HB_RED_LO  = 5'd1;
  localparam logic [4:0] HB_PEACH   = 5'd3;
  localparam logic [4:0] HB_YELLOW  = 5'd5;
  localparam logic [4:0] HB_GREEN   = 5'd11;
  localparam logic [4:0] HB_BLUE    = 5'd17;
  localparam logic [4:0] HB_MAUVE   = 5'd21;
  localparam logic [4:0] HB_RED_HI  = 5'd23;

endpackage

`default_nettype wire

>>> sv/pcfc_classify.sv
// Combinational color family decision for one RGB pixel.
// Depends on pcfc_pkg for widths, thresholds and the family codes.
`timescale 1ns / 1ps
`default_nettype none

module pcfc_classify
  import pcfc_pkg::*;
(
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  output family_t               family
);

  logic [PIX_W-1:0]   hi;
  logic [PIX_W-1:0]   lo;
  logic [PIX_W-1:0]   spread;
  logic [HUE_T_W-1:0] t;
  logic [HUE_C_W-1:0] t4;

  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi)  hi = blue;
    if (green < lo) lo = green;
    if (blue < lo)  lo = blue;
    spread = hi - lo;
  end

  // t = hs / 60; red sector wraps by adding a full turn (6 * spread).
  // Mod-2^11 math is exact since the true result lies in [0, 6*spread).
  always_comb begin
    if (hi == red) begin
      if (green >= blue) begin
        t = HUE_T_W'(green) - HUE_T_W'(blue);
      end else begin
        t = HUE_T_W'(spread) * HUE_T_W'(6) + HUE_T_W'(green) - HUE_T_W'(blue);
      end
    end else if (hi == green) begin
      t = HUE_T_W'(spread) * HUE_T_W'(2) + HUE_T_W'(blue) - HUE_T_W'(red);
    end else begin
      t = HUE_T_W'(spread) * HUE_T_W'(4) + HUE_T_W'(red) - HUE_T_W'(green);
    end
    t4 = {t, 2'b00};
  end

  // 60*t < B*s  <=>  4*t < (B/15)*s
  function automatic logic below(input logic [HUE_C_W-1:0] lhs,
                                 input logic [PIX_W-1:0]   s,
                                 input logic [4:0]         m);
    logic [HUE_C_W-1:0] rhs;
    rhs = HUE_C_W'(s) * HUE_C_W'(m);
    return lhs < rhs;
  endfunction

  always_comb begin
    priority if (hi >= WHITE_MAX_MIN && lo >= WHITE_MIN_MIN) begin
      family = FAM_WHITE;
    end else if (hi <= BLACK_MAX_MAX) begin
      family = FAM_BLACK;
    end else if (spread <= GRAY_SPREAD) begin
      priority if (hi >= LIGHTGRAY_MIN) family = FAM_LIGHTGRAY;
      else if (hi >= GRAY_MIN)          family = FAM_GRAY;
      else                              family = FAM_DARKGRAY;
    end else if (below(t4, spread, HB_RED_LO) || !below(t4, spread, HB_RED_HI)) begin
      family = FAM_RED;
    end else if (below(t4, spread, HB_PEACH)) begin
      family = FAM_PEACH;
    end else if (below(t4, spread, HB_YELLOW)) begin
      family = FAM_YELLOW;
    end else if (below(t4, spread, HB_GREEN)) begin
      family = FAM_GREEN;
    end else if (below(t4, spread, HB_BLUE)) begin
      family = FAM_BLUE;
    end else if (below(t4, spread, HB_MAUVE)) begin
      family = FAM_MAUVE;
    end else begin
      family = FAM_PINK;
    end
  end

endmodule

`default_nettype wire

>>> sv/pixel_color_family_classifier_unit.sv
// Pixel color family classifier: pixel register, combinational classify, then family register.
// Throughput one item per cycle while family_stall is low; the pixel register and the family register
// each hand off in the same cycle the next stage frees up.
// Reset (rst, synchronous, active high) empties both stages; no other state.
// Depends on pcfc_pkg and pcfc_classify.
`timescale 1ns / 1ps
`default_nettype none

module pixel_color_family_classifier_unit
  import pcfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // pixel channel
  input  wire logic             pixel_valid,
  output logic                  pixel_stall,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  // family channel
  output logic                  family_valid,
  input  wire logic             family_stall,
  output logic [FAM_W-1:0]      family
);

  // Stage 1: registered pixel
  logic             pix_valid;
  logic [PIX_W-1:0] pix_red;
  logic [PIX_W-1:0] pix_green;
  logic [PIX_W-1:0] pix_blue;

  // Stage 2 can take a new item when empty or being drained this cycle
  logic    res_take;
  family_t fam_calc;

  assign res_take    = !family_valid || !family_stall;
  // Stage 1 only holds off the source when it is full and stage 2 cannot move
  assign pixel_stall = pix_valid && !res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pixel_stall) begin
      pix_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pixel_stall && pixel_valid) begin
      pix_red   <= red;
      pix_green <= green;
      pix_blue  <= blue;
    end
  end

  pcfc_classify u_classify (
    .red    (pix_red),
    .green  (pix_green),
    .blue   (pix_blue),
    .family (fam_calc)
  );

  // Stage 2: result register, drives the family port directly
  always_ff @(posedge clk) begin
    if (rst) begin
      family_valid <= 1'b0;
    end else if (res_take) begin
      family_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && pix_valid) begin
      family <= FAM_W'(fam_calc);
    end
  end

`ifndef ASSERT_OFF
  // Source is only held off when both stages are occupied
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (pix_valid && family_valid))
    else $error("pixel stalled with a free stage");

  // A registered pixel moves to the result register when the sink is open
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !family_stall) |=> family_valid)
    else $error("stage 1 item did not advance");

  // Into an empty pipe, an item passes the pixel register, then the family register, to the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall && !pix_valid && !family_valid) |-> ##2 family_valid)
    else $error("latency not two cycles");

  // A neutral pixel (all channels equal) entering an empty pipe is never given a hue family
  a_neutral: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall && !pix_valid && !family_valid
     && red == green && green == blue) |-> ##2 (family <= FAM_W'(FAM_BLACK)))
    else $error("neutral pixel classified as hue");
`endif

endmodule

`default_nettype wire

>>> test/pcfc_family_checker.sv
// Scoreboard for the pixel color family classifier: predicts the family of
// every accepted pixel and compares it with each accepted family item.
// Depends on pcfc_pkg for the family codes.
`timescale 1ns / 1ps

module pcfc_family_checker
  import pcfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  input  logic             pixel_stall,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  input  logic             family_valid,
  input  logic             family_stall,
  input  logic [FAM_W-1:0] family,
  output int               fail_count,
  output int               n_pending
);

  family_t expected_families[$];

  // Hue is compared as hue * spread against boundary * spread, no division.
  function automatic family_t predict_family(input logic [PIX_W-1:0] r, g, b);
    int ri, gi, bi, hi, lo, spread, hs;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    spread = hi - lo;
    if (hi >= 245 && lo >= 235) return FAM_WHITE;
    if (hi <= 22) return FAM_BLACK;
    if (spread <= 14) begin
      if (hi >= 205) return FAM_LIGHTGRAY;
      if (hi >= 110) return FAM_GRAY;
      return FAM_DARKGRAY;
    end
    // sector from the max channel; ties go red, then green
    if (hi == ri) begin
      hs = 60 * (gi - bi);
      if (hs < 0) hs += 360 * spread;
    end else if (hi == gi) begin
      hs = 60 * (2 * spread + bi - ri);
    end else begin
      hs = 60 * (4 * spread + ri - gi);
    end
    if (hs < 15 * spread || hs >= 345 * spread) return FAM_RED;
    if (hs < 45 * spread) return FAM_PEACH;
    if (hs < 75 * spread) return FAM_YELLOW;
    if (hs < 165 * spread) return FAM_GREEN;
    if (hs < 255 * spread) return FAM_BLUE;
    if (hs < 315 * spread) return FAM_MAUVE;
    return FAM_PINK;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    family_t want;
    if (rst) begin
      fail_count = 0;
      n_pending <= 0;
    end else begin
      if (pixel_valid && !pixel_stall)
        expected_families.push_back(predict_family(red, green, blue));
      if (family_valid && !family_stall) begin
        if (expected_families.size() == 0) begin
          report_mismatch($sformatf("family %0d with no pixel waiting", family));
        end else begin
          want = expected_families.pop_front();
          if (family !== want)
            report_mismatch($sformatf("family got %0d want %0d", family, want));
        end
      end
      n_pending <= expected_families.size();
    end
  end

endmodule

>>> test/tb.sv
// Top of the classifier testbench: clock, reset, pixel stimulus, family-side
// stalls and the verdict. Depends on pcfc_pkg, the classifier unit and
// pcfc_family_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;
  import pcfc_pkg::*;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int CYCLE_LIMIT     = 200000;

  logic             clk;
  logic             rst;
  logic             pixel_valid;
  logic             pixel_stall;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             family_valid;
  logic             family_stall;
  logic [FAM_W-1:0] family;

  int fail_count;
  int n_pending;
  int cycle_count = 0;

  // percent chance per cycle that the sender idles / the receiver stalls
  int send_idle_pct;
  int stall_pct;

  // Directed pixels, {red, green, blue}: extremes, threshold edges, ties and
  // hues that sit exactly on a sector boundary (boundary goes to the upper side).
  localparam logic [23:0] DIRECTED[24] = '{
    {8'd0,   8'd0,   8'd0  },  // black
    {8'd255, 8'd255, 8'd255},  // white
    {8'd245, 8'd235, 8'd235},  // white at both minimums
    {8'd244, 8'd240, 8'd240},  // just below white: lightgray
    {8'd245, 8'd234, 8'd240},  // min one short of white
    {8'd22,  8'd0,   8'd0  },  // brightest black
    {8'd23,  8'd23,  8'd23 },  // darkest darkgray
    {8'd110, 8'd100, 8'd100},  // gray floor
    {8'd205, 8'd191, 8'd200},  // lightgray floor, spread 14
    {8'd109, 8'd109, 8'd95 },  // darkgray, spread 14
    {8'd100, 8'd85,  8'd85 },  // spread 15: chromatic
    {8'd255, 8'd0,   8'd0  },  // pure red
    {8'd0,   8'd255, 8'd0  },  // pure green
    {8'd0,   8'd0,   8'd255},  // pure blue
    {8'd255, 8'd255, 8'd0  },  // red/green tie
    {8'd0,   8'd255, 8'd255},  // green/blue tie
    {8'd255, 8'd0,   8'd255},  // red/blue tie
    {8'd100, 8'd25,  8'd0  },  // hue 15
    {8'd100, 8'd24,  8'd0  },  // just under 15
    {8'd100, 8'd0,   8'd25 },  // hue 345
    {8'd100, 8'd75,  8'd0  },  // hue 45
    {8'd75,  8'd100, 8'd0  },  // hue 75
    {8'd0,   8'd100, 8'd75 },  // hue 165
    {8'd25,  8'd0,   8'd100}   // hue 255
  };

  pixel_color_family_classifier_unit dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .family_valid (family_valid),
    .family_stall (family_stall),
    .family       (family)
  );

  pcfc_family_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .family_valid (family_valid),
    .family_stall (family_stall),
    .family       (family),
    .fail_count   (fail_count),
    .n_pending    (n_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: random stalls per phase
  always @(posedge clk) begin
    if (rst) begin
      family_stall <= 1'b0;
    end else begin
      family_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[pixel_color_family_classifier_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] clamp8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[PIX_W-1:0];
  endfunction

  // Offer one item; returns right after the edge that accepted it.
  // Stall is sampled at the falling edge, where it already holds its value
  // for the coming rising edge.
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    do begin
      @(negedge clk);
      stalled = pixel_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Random pixel: mostly shaped toward thresholds and sector boundaries.
  task automatic pick_pixel(output logic [PIX_W-1:0] r, g, b);
    int sel, base, lo, s, hi, mid;
    sel = $urandom_range(0, 9);
    if (sel <= 2) begin
      r = PIX_W'($urandom_range(0, 255));
      g = PIX_W'($urandom_range(0, 255));
      b = PIX_W'($urandom_range(0, 255));
    end else if (sel == 3) begin
      // near-gray: small spread around a random level
      base = $urandom_range(0, 255);
      r = clamp8(base + $urandom_range(0, 20) - 10);
      g = clamp8(base + $urandom_range(0, 20) - 10);
      b = clamp8(base + $urandom_range(0, 20) - 10);
    end else if (sel == 4) begin
      r = PIX_W'($urandom_range(228, 255));
      g = PIX_W'($urandom_range(228, 255));
      b = PIX_W'($urandom_range(228, 255));
    end else if (sel == 5) begin
      r = PIX_W'($urandom_range(0, 30));
      g = PIX_W'($urandom_range(0, 30));
      b = PIX_W'($urandom_range(0, 30));
    end else begin
      // middle channel near a quarter of the spread: lands on or next to
      // a sector boundary; quarters 0 and 4 give channel ties
      lo  = $urandom_range(0, 240);
      s   = $urandom_range(15, 255 - lo);
      hi  = lo + s;
      mid = lo + (s * $urandom_range(0, 4)) / 4 + $urandom_range(0, 2) - 1;
      if (mid < lo) mid = lo;
      if (mid > hi) mid = hi;
      case ($urandom_range(0, 5))
        0: begin r = PIX_W'(hi);  g = PIX_W'(mid); b = PIX_W'(lo);  end
        1: begin r = PIX_W'(hi);  g = PIX_W'(lo);  b = PIX_W'(mid); end
        2: begin r = PIX_W'(mid); g = PIX_W'(hi);  b = PIX_W'(lo);  end
        3: begin r = PIX_W'(lo);  g = PIX_W'(hi);  b = PIX_W'(mid); end
        4: begin r = PIX_W'(mid); g = PIX_W'(lo);  b = PIX_W'(hi);  end
        default: begin r = PIX_W'(lo); g = PIX_W'(mid); b = PIX_W'(hi); end
      endcase
    end
  endtask

  task automatic random_phase(input int idle_pct, input int stall_percent);
    logic [PIX_W-1:0] r, g, b;
    send_idle_pct = idle_pct;
    stall_pct     = stall_percent;
    repeat (ITEMS_PER_PHASE) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    rst          <= 1'b1;
    pixel_valid  <= 1'b0;
    red          <= '0;
    green        <= '0;
    blue         <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_pixel(DIRECTED[i][23:16], DIRECTED[i][15:8], DIRECTED[i][7:0]);

    random_phase(0, 0);    // back to back, no stalls
    random_phase(84, 0);   // sparse sender
    random_phase(0, 84);   // heavy back-pressure
    random_phase(32, 32);  // both sides jittery
    pixel_valid <= 1'b0;

    // drain, then wait for anything stray out of the two-stage pipe
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (6) @(posedge clk);

    if (fail_count == 0) begin
      $display("[pixel_color_family_classifier_unit] OK");
    end else begin
      $display("[pixel_color_family_classifier_unit] ERROR");
    end
    $finish;
  end

endmodule
